/* rtl/mkde_pkg.sv */
`timescale 1ns / 1ps
// Package for the multi-key debounce event block: key count, field widths
// and the packed request and response transaction types. No dependencies.
package mkde_pkg;

   localparam int NUM_KEYS        = 7;
   localparam int KEY_IDX_W       = 3;
   localparam int TIME_W          = 32;
   localparam int DEBOUNCE_W      = 16;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   typedef struct packed {
      logic [NUM_KEYS-1:0] key_levels;
      logic [TIME_W-1:0]   now_ms;
   } mkde_req_type;

   typedef struct packed {
      logic                 event_valid;
      logic [KEY_IDX_W-1:0] event_key;
      logic                 event_pressed;
      logic [TIME_W-1:0]    event_time_ms;
      logic                 any_pressed;
      logic [TIME_W-1:0]    press_time_ms;
   } mkde_rsp_type;

endpackage

/* rtl/multi_key_debounce_event.sv */
`timescale 1ns / 1ps
// Multi-key timestamp debouncer, at most one event per poll, fixed key priority.
// Depends on mkde_pkg for widths, key count and transaction types.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  req     | in        | req_valid/req_ready  | req_data (mkde_req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (mkde_rsp_type)
//  csr     | in        | csr_wr_en, no wait   | csr_wr_data (debounce ms)
//
// One poll per cycle sustained while rsp_ready stays high; a poll is registered in the
// input register, then its result in the result register, held there until rsp_ready.
// The key state updates at the same edge the result register loads, so the
// next poll in the input register always sees the state this one leaves.
// A stalled result holds the result register and then the input register.
// Reset (synchronous) clears all key state and sets the debounce time to 20.
module multi_key_debounce_event (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mkde_pkg::mkde_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mkde_pkg::mkde_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [mkde_pkg::DEBOUNCE_W-1:0] csr_wr_data
);
   import mkde_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  in_valid_ff;
   mkde_req_type          in_ff;
   logic                  rsp_valid_ff;
   mkde_rsp_type          rsp_ff;
   logic                  adv;

   logic [NUM_KEYS-1:0] sampled_ff, sampled_in;
   logic [NUM_KEYS-1:0] stable_ff, stable_in;
   logic [TIME_W-1:0]   change_ff [NUM_KEYS];
   logic [TIME_W-1:0]   change_in [NUM_KEYS];
   logic [TIME_W-1:0]   last_press_ff, last_press_in;

   logic [TIME_W-1:0]   change_new [NUM_KEYS];
   logic [NUM_KEYS-1:0] elig;
   logic [NUM_KEYS-1:0] touch;
   logic [NUM_KEYS-1:0] win;
   mkde_rsp_type        rsp_in;

   // advance the input register into the result stage when the output slot frees
   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // per-key change time and debounce check, all keys in parallel
   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         change_new[k] = (in_ff.key_levels[k] != sampled_ff[k]) ? in_ff.now_ms
                                                                 : change_ff[k];
         elig[k] = (in_ff.key_levels[k] != stable_ff[k]) &&
                   ((in_ff.now_ms - change_new[k]) >=
                    {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff});
      end
   end

   // priority: first eligible key wins, keys after it are left untouched
   always_comb begin
      logic earlier;
      earlier = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         touch[k] = !earlier;
         win[k]   = elig[k] && !earlier;
         earlier  = earlier || elig[k];
      end
   end

   always_comb begin
      sampled_in    = sampled_ff;
      stable_in     = stable_ff;
      last_press_in = last_press_ff;
      rsp_in        = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         change_in[k] = change_ff[k];
         if (touch[k]) begin
            sampled_in[k] = in_ff.key_levels[k];
            change_in[k]  = change_new[k];
         end
         if (win[k]) begin
            stable_in[k]         = in_ff.key_levels[k];
            rsp_in.event_valid   = 1'b1;
            rsp_in.event_key     = KEY_IDX_W'(k);
            rsp_in.event_pressed = in_ff.key_levels[k];
            rsp_in.event_time_ms = in_ff.now_ms;
            if (in_ff.key_levels[k]) begin
               last_press_in = in_ff.now_ms;
            end
         end
      end
      rsp_in.any_pressed   = |in_ff.key_levels;
      rsp_in.press_time_ms = last_press_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sampled_ff    <= '0;
         stable_ff     <= '0;
         last_press_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            change_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            debounce_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (adv) begin
            rsp_valid_ff  <= 1'b1;
            sampled_ff    <= sampled_in;
            stable_ff     <= stable_in;
            last_press_ff <= last_press_in;
            for (int k = 0; k < NUM_KEYS; k++) begin
               change_ff[k] <= change_in[k];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   a_one_winner: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> $onehot0(win))
      else $error("more than one key won the priority chain");

   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.event_valid |->
         rsp_ff.event_key == '0 && !rsp_ff.event_pressed &&
         rsp_ff.event_time_ms == '0)
      else $error("event fields not cleared on a poll without event");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_valid |->
         rsp_ff.event_key < KEY_IDX_W'(NUM_KEYS))
      else $error("event key out of range");

   a_last_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.press_time_ms == last_press_ff)
      else $error("reported press time differs from stored press time");

   a_press_time: assert property (@(posedge clock) disable iff (reset)
      adv && rsp_in.event_valid && rsp_in.event_pressed |=>
         last_press_ff == rsp_ff.event_time_ms)
      else $error("debounced press did not update last press time");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for multi_key_debounce_event: directed and random key polls, checked
// against an in-bench debounce predictor through an in-order result scoreboard.
// Depends on mkde_pkg and the multi_key_debounce_event RTL.
module tb_top;
   import mkde_pkg::*;

   localparam int IDLE_PCT        = 37;
   localparam int RESET_CYCLES    = 11;
   localparam int MAX_REPORTS     = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RAND_PHASES     = 6;
   localparam int CALM_PHASE      = 3;
   localparam int POLLS_PER_PHASE = 215;

   class debounce_scoreboard;
      logic [DEBOUNCE_W-1:0] hold_ms;
      logic [NUM_KEYS-1:0]   sampled;
      logic [NUM_KEYS-1:0]   stable;
      logic [TIME_W-1:0]     change_ms [NUM_KEYS];
      logic [TIME_W-1:0]     last_press_ms;
      mkde_rsp_type          expected_q [$];
      int                    mismatches;
      int                    checked;
      int                    key_events;

      function new();
         hold_ms       = DEBOUNCE_RESET;
         sampled       = '0;
         stable        = '0;
         last_press_ms = '0;
         mismatches    = 0;
         checked       = 0;
         key_events    = 0;
         foreach (change_ms[k]) change_ms[k] = '0;
      endfunction

      // Advance the key state by one poll and queue the result it must produce.
      function void note_poll(mkde_req_type poll);
         mkde_rsp_type      exp_rsp;
         logic [TIME_W-1:0] held_ms;
         bit                fired;
         exp_rsp = '0;
         fired   = 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (!fired) begin
               if (poll.key_levels[k] != sampled[k]) begin
                  sampled[k]   = poll.key_levels[k];
                  change_ms[k] = poll.now_ms;
               end
               held_ms = poll.now_ms - change_ms[k];
               if (stable[k] != sampled[k] && held_ms >= {16'b0, hold_ms}) begin
                  stable[k]             = sampled[k];
                  fired                 = 1'b1;
                  exp_rsp.event_valid   = 1'b1;
                  exp_rsp.event_key     = KEY_IDX_W'(k);
                  exp_rsp.event_pressed = stable[k];
                  exp_rsp.event_time_ms = poll.now_ms;
                  if (stable[k]) last_press_ms = poll.now_ms;
               end
            end
         end
         exp_rsp.any_pressed   = |poll.key_levels;
         exp_rsp.press_time_ms = last_press_ms;
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_result(mkde_rsp_type got);
         mkde_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected result: v=%0b key=%0d p=%0b t=%h act=%0b last=%h",
                        got.event_valid, got.event_key, got.event_pressed,
                        got.event_time_ms, got.any_pressed, got.press_time_ms);
            mismatches++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         checked++;
         if (exp_rsp.event_valid) key_events++;
         if (got.event_valid   !== exp_rsp.event_valid   ||
             got.event_key     !== exp_rsp.event_key     ||
             got.event_pressed !== exp_rsp.event_pressed ||
             got.event_time_ms !== exp_rsp.event_time_ms ||
             got.any_pressed   !== exp_rsp.any_pressed   ||
             got.press_time_ms !== exp_rsp.press_time_ms) begin
            if (mismatches < MAX_REPORTS) begin
               $display("result %0d mismatch", checked);
               $display("  expected v=%0b key=%0d p=%0b t=%h act=%0b last=%h",
                        exp_rsp.event_valid, exp_rsp.event_key, exp_rsp.event_pressed,
                        exp_rsp.event_time_ms, exp_rsp.any_pressed,
                        exp_rsp.press_time_ms);
               $display("  actual   v=%0b key=%0d p=%0b t=%h act=%0b last=%h",
                        got.event_valid, got.event_key, got.event_pressed,
                        got.event_time_ms, got.any_pressed, got.press_time_ms);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   mkde_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   mkde_rsp_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [DEBOUNCE_W-1:0] csr_wr_data = '0;

   debounce_scoreboard    sb;
   bit                    req_idle_en = 1'b1;
   bit                    rsp_idle_en = 1'b1;
   int                    polls_sent = 0;
   int                    settings_used = 0;
   int                    cycle_count = 0;
   logic [DEBOUNCE_W-1:0] phase_hold [RAND_PHASES];
   logic [TIME_W-1:0]     phase_start [RAND_PHASES];

   multi_key_debounce_event uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.expected_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random back-pressure, check every accepted transaction.
   always @(negedge clock) begin
      if (rsp_idle_en) begin
         rsp_ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   task automatic send_poll(input logic [NUM_KEYS-1:0] levels,
                            input logic [TIME_W-1:0] t_ms);
      @(negedge clock);
      while (req_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{key_levels: levels, now_ms: t_ms};
      do @(posedge clock); while (!req_ready);
      sb.note_poll(req_data);
      polls_sent++;
   endtask

   // Drop valid, drain all expected results, then write the debounce time.
   task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      sb.hold_ms = value;
      settings_used++;
   endtask

   // Mostly steady time with occasional key changes so debounces complete;
   // the rest jumps or rewinds time and scrambles the levels.
   task automatic run_phase(input logic [DEBOUNCE_W-1:0] hold,
                            input logic [TIME_W-1:0] start_ms, input int count);
      int unsigned         span;
      int                  pick;
      int                  idx;
      logic [TIME_W-1:0]   t_ms;
      logic [NUM_KEYS-1:0] levels;
      write_debounce(hold);
      span   = hold / 3 + 2;
      t_ms   = start_ms;
      levels = NUM_KEYS'($urandom);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if ($urandom_range(0, 9) == 0) begin
               t_ms += hold + $urandom_range(0, 3);
            end else begin
               t_ms += $urandom_range(0, span);
            end
            if ($urandom_range(0, 99) < 15) begin
               idx         = $urandom_range(0, NUM_KEYS - 1);
               levels[idx] = ~levels[idx];
            end else if ($urandom_range(0, 99) < 5) begin
               levels = NUM_KEYS'($urandom);
            end
         end else if (pick < 87) begin
            t_ms   = $urandom;
            levels = NUM_KEYS'($urandom);
         end else if (pick < 94) begin
            t_ms -= $urandom_range(1, span);
         end else begin
            levels = NUM_KEYS'($urandom);
         end
         send_poll(levels, t_ms);
      end
   endtask

   initial begin
      sb = new();
      phase_hold[0]  = 16'hFFFF;
      phase_hold[1]  = 16'd1;
      phase_hold[2]  = 16'd0;
      phase_hold[3]  = 16'd20;
      phase_hold[4]  = DEBOUNCE_W'($urandom_range(2, 4000));
      phase_hold[5]  = 16'd300;
      phase_start[0] = 32'hFFF0_0000;
      phase_start[1] = 32'hFFFF_FFA0;
      for (int p = 2; p < RAND_PHASES; p++) phase_start[p] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset debounce time: hold just short, then press keys one per poll.
      send_poll(7'h00, 32'd0);
      send_poll(7'h7F, 32'd5);
      send_poll(7'h7F, 32'd24);
      repeat (NUM_KEYS + 1) send_poll(7'h7F, 32'd25);
      send_poll(7'h00, 32'd100);
      // time steps back: wrapped difference counts as a long hold
      send_poll(7'h00, 32'd99);
      // hold across the 32-bit time wrap
      send_poll(7'h55, 32'hFFFF_FFF0);
      send_poll(7'h55, 32'h0000_0010);
      send_poll(7'h7F, 32'hFFFF_FFFF);

      // Zero debounce: a change is taken in the poll that sees it.
      write_debounce(16'd0);
      send_poll(7'h01, 32'd1000);
      send_poll(7'h01, 32'd1000);
      send_poll(7'h03, 32'd1000);
      send_poll(7'h02, 32'd1000);
      send_poll(7'h00, 32'd1000);

      // Longest debounce: one short, then exactly enough.
      write_debounce(16'hFFFF);
      send_poll(7'h40, 32'd5000);
      send_poll(7'h40, 32'd70534);
      send_poll(7'h40, 32'd70535);
      send_poll(7'h00, 32'd70535);

      for (int p = 0; p < RAND_PHASES; p++) begin
         req_idle_en = (p != CALM_PHASE);
         rsp_idle_en = (p != CALM_PHASE);
         run_phase(phase_hold[p], phase_start[p], POLLS_PER_PHASE);
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d polls under %0d debounce settings (0 to 65535 ms), %0d checked",
               polls_sent, settings_used + 1, sb.checked);
      $display("saw %0d debounced key events, %0d mismatches", sb.key_events, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
